// ===== design/pdca_pkg.sv =====
// Shared types and constants for the PWM duty capture to angle block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pdca_pkg;

  localparam int TICK_W   = 16;
  localparam int FULL_W   = 9;
  localparam int ANGLE_W  = 12;
  localparam int FULL10_W = 13;
  localparam int QUOT_W   = 13;
  localparam int CNT_W    = 4;

  localparam logic [FULL_W-1:0]  FULL_RESET = 9'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 12'hFFF;

  typedef struct packed {
    logic cap_rise;
    logic cap_fall;
    logic cap_third;
    logic prep;
    logic cmp;
    logic mul;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== design/pdca_datapath.sv =====
// Datapath: capture timestamps, tick differences, duty classification,
// scale multiply, restoring divider and the result register. Uses pdca_pkg.
`timescale 1ns / 1ps

module pdca_datapath import pdca_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [TICK_W-1:0]  capture_time,
  input  logic               cfg_wr_en,
  input  logic [FULL_W-1:0]  full_scale_angle,
  output logic [ANGLE_W-1:0] angle_tenths,
  output logic [TICK_W-1:0]  high_ticks,
  output logic [TICK_W-1:0]  low_ticks,
  output logic               period_zero
);

  localparam int PW  = TIMER_BITS + 1;
  localparam int HW  = TIMER_BITS + 4;
  localparam int P9W = TIMER_BITS + 5;
  localparam int DW  = TIMER_BITS + 4;
  localparam int NW  = DW + QUOT_W;

  logic [FULL_W-1:0]     full_scale;
  logic [TIMER_BITS-1:0] last_edge;
  logic [TIMER_BITS-1:0] high_time;
  logic [TIMER_BITS-1:0] low_time;
  logic [PW-1:0]         period;
  logic [HW-1:0]         hi10;
  logic [P9W-1:0]        p9;
  logic [FULL10_W-1:0]   full10;
  logic                  below;
  logic                  above;
  logic                  zero;
  logic [HW-1:0]         spread;
  logic [DW-1:0]         divisor;
  logic [DW-1:0]         rem;
  logic [QUOT_W-1:0]     num_low;
  logic [QUOT_W-1:0]     quot;
  logic [CNT_W-1:0]      cnt;

  logic [TIMER_BITS-1:0] stamp;
  logic [TIMER_BITS-1:0] diff_now;
  logic [TICK_W-1:0]     high_out;
  logic [TICK_W-1:0]     low_out;
  logic [HW-1:0]         period_ext;
  logic [NW-1:0]         prod;
  logic [DW:0]           trial;
  logic [DW:0]           trial_sub;
  logic                  trial_ge;
  logic [FULL10_W-1:0]   angle_raw;
  logic [ANGLE_W-1:0]    angle_sat;

  generate
    if (TIMER_BITS > TICK_W) begin : g_wide
      assign stamp    = {{(TIMER_BITS-TICK_W){1'b0}}, capture_time};
      assign high_out = high_time[TICK_W-1:0];
      assign low_out  = low_time[TICK_W-1:0];
    end else if (TIMER_BITS == TICK_W) begin : g_equal
      assign stamp    = capture_time;
      assign high_out = high_time;
      assign low_out  = low_time;
    end else begin : g_narrow
      assign stamp    = capture_time[TIMER_BITS-1:0];
      assign high_out = {{(TICK_W-TIMER_BITS){1'b0}}, high_time};
      assign low_out  = {{(TICK_W-TIMER_BITS){1'b0}}, low_time};
    end
  endgenerate

  assign diff_now   = stamp - last_edge;
  assign period_ext = {{(HW-PW){1'b0}}, period};
  assign prod       = {{(NW-FULL10_W){1'b0}}, full10} * {{QUOT_W{1'b0}}, spread};
  assign trial      = {rem, num_low[QUOT_W-1]};
  assign trial_sub  = trial - {1'b0, divisor};
  assign trial_ge   = trial >= {1'b0, divisor};

  assign status.div_last = (cnt == CNT_W'(QUOT_W - 1));

  always_comb begin
    if (zero || below) begin
      angle_raw = '0;
    end else if (above) begin
      angle_raw = full10;
    end else begin
      angle_raw = quot;
    end
    if (angle_raw > {1'b0, ANGLE_MAX}) begin
      angle_sat = ANGLE_MAX;
    end else begin
      angle_sat = angle_raw[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_RESET;
      last_edge  <= '0;
      high_time  <= '0;
    end else begin
      if (cfg_wr_en) begin
        full_scale <= full_scale_angle;
      end
      if (cmd.cap_rise) begin
        last_edge <= stamp;
      end
      if (cmd.cap_fall) begin
        high_time <= diff_now;
        last_edge <= stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_third) begin
      low_time <= diff_now;
      period   <= {1'b0, high_time} + {1'b0, diff_now};
    end
    if (cmd.prep) begin
      hi10   <= {1'b0, high_time, 3'b000} + {3'b000, high_time, 1'b0};
      p9     <= {1'b0, period, 3'b000} + {4'b0000, period};
      full10 <= {1'b0, full_scale, 3'b000} + {3'b000, full_scale, 1'b0};
    end
    if (cmd.cmp) begin
      below   <= hi10 < period_ext;
      above   <= {1'b0, hi10} > p9;
      zero    <= period == '0;
      spread  <= hi10 - period_ext;
      divisor <= {period, 3'b000};
    end
    if (cmd.mul) begin
      rem     <= prod[NW-1:QUOT_W];
      num_low <= prod[QUOT_W-1:0];
      quot    <= '0;
      cnt     <= '0;
    end
    if (cmd.div_step) begin
      rem     <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      quot    <= {quot[QUOT_W-2:0], trial_ge};
      num_low <= {num_low[QUOT_W-2:0], 1'b0};
      cnt     <= cnt + 1'b1;
    end
    if (cmd.load_out) begin
      angle_tenths <= angle_sat;
      high_ticks   <= high_out;
      low_ticks    <= low_out;
      period_zero  <= zero;
    end
  end

endmodule

// ===== design/pdca_ctrl.sv =====
// Controller: capture phase tracking, compute sequencing and result valid.
// Drives datapath commands from pdca_pkg types.
`timescale 1ns / 1ps

module pdca_ctrl import pdca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  localparam logic [1:0] PH_WAIT_RISE = 2'd0;
  localparam logic [1:0] PH_WAIT_FALL = 2'd1;
  localparam logic [1:0] PH_WAIT_END  = 2'd2;

  state_t     state;
  state_t     state_next;
  logic [1:0] phase;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.cap_fall  = accept && (phase == PH_WAIT_FALL);
    cmd.cap_third = accept && (phase == PH_WAIT_END);
    cmd.cap_rise  = accept && (phase != PH_WAIT_FALL) && (phase != PH_WAIT_END);
    cmd.prep      = (state == ST_PREP);
    cmd.cmp       = (state == ST_CMP);
    cmd.mul       = (state == ST_MUL);
    cmd.div_step  = (state == ST_DIV);
    cmd.load_out  = (state == ST_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.cap_third) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: state_next = ST_CMP;
      ST_CMP:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_WAIT_RISE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cap_rise) begin
        phase <= PH_WAIT_FALL;
      end else if (cmd.cap_fall) begin
        phase <= PH_WAIT_END;
      end else if (cmd.cap_third) begin
        phase <= PH_WAIT_RISE;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/pwm_duty_capture_to_angle.sv =====
// Top level of the PWM duty capture to angle block.
// Instantiates pdca_ctrl and pdca_datapath; uses pdca_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/capture_time) takes one timer capture
//   per request, in rising, falling, rising order. Rising and falling
//   captures are taken while idle and give no result. The closing rising
//   capture starts the angle computation and yields one result request on
//   the output channel (out_valid/out_stall): angle_tenths, high_ticks,
//   low_ticks, period_zero.
//   The closing capture runs through the prep, compare and multiply states,
//   a 13-step restoring divider and a finish state. Sustained rate is
//   one request per cycle for the first two captures of a period while
//   idle; the third stalls the input until its result is loaded.
//   The output register holds a finished result while out_stall is high;
//   the block still takes the next two captures meanwhile, and a new
//   result waits in the last compute state until the register frees.
//   Reset (rst, synchronous) clears the phase to await a rising edge,
//   drops any pending result and sets the stored full scale to 180 degrees.
//   cfg_wr_en writes full_scale_angle; write only while idle.
`timescale 1ns / 1ps

module pwm_duty_capture_to_angle import pdca_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TICK_W-1:0]  capture_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ANGLE_W-1:0] angle_tenths,
  output logic [TICK_W-1:0]  high_ticks,
  output logic [TICK_W-1:0]  low_ticks,
  output logic               period_zero,
  input  logic               cfg_wr_en,
  input  logic [FULL_W-1:0]  full_scale_angle
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pdca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pdca_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .capture_time     (capture_time),
    .cfg_wr_en        (cfg_wr_en),
    .full_scale_angle (full_scale_angle),
    .angle_tenths     (angle_tenths),
    .high_ticks       (high_ticks),
    .low_ticks        (low_ticks),
    .period_zero      (period_zero)
  );

  a_zero_period_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_zero |-> angle_tenths == '0)
    else $error("zero period result carries a nonzero angle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a compute pass");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result raised right after a capture");

endmodule
